### rtl/core/afs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the animation frame sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

   localparam int FRAME_BITS    = 16;
   localparam int TIME_BITS     = 32;
   localparam int INTERVAL_BITS = 16;
   localparam int SKIP_BITS     = 8;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_PAUSE   = 2'd2,
      CMD_RESUME  = 2'd3
   } command_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FIRST_FRAME    = 3'd0,
      CSR_LAST_FRAME     = 3'd1,
      CSR_FRAME_INTERVAL = 3'd2,
      CSR_SKIP_STEP      = 3'd3,
      CSR_BOTH_WAY       = 3'd4,
      CSR_PLAY_ONCE      = 3'd5
   } csr_index_type;

   // Stage enables from the sequencer to the frame unit.
   typedef struct packed {
      logic count_en;
      logic mul_en;
      logic step_en;
      logic wrap_en;
   } stage_ctl_type;

endpackage

### rtl/core/afs_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module afs_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [afs_pkg::TIME_BITS-1:0]        dividend,
   input  logic [afs_pkg::INTERVAL_BITS-1:0]    divisor,
   output logic                                 done,
   output logic [afs_pkg::TIME_BITS-1:0]        quotient
);

   localparam int TB = afs_pkg::TIME_BITS;
   localparam int DB = afs_pkg::INTERVAL_BITS;
   localparam int CNT_BITS = $clog2(TB);

   logic [TB-1:0]       acc_ff, acc_in;
   logic [DB-1:0]       rem_ff, rem_in;
   logic [DB-1:0]       div_ff, div_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DB:0]         trial;
   logic [DB:0]         diff;
   logic                qbit;

   always_comb begin
      trial = {rem_ff, acc_ff[TB-1]};
      diff  = trial - {1'b0, div_ff};
      qbit  = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_BITS'(TB - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[TB-2:0], qbit};
         rem_in = qbit ? diff[DB-1:0] : trial[DB-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = acc_ff;

endmodule

### rtl/core/afs_frame_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_frame_unit
// Frame update pipeline: interval count, step multiply, bounded step, and
// end-of-run wrap or ping-pong turn.
// ----------------------------------------------------------------------------
module afs_frame_unit (
   input  logic                                 clock,
   input  afs_pkg::stage_ctl_type               ctl,
   input  logic [afs_pkg::TIME_BITS-1:0]        quotient,
   input  logic                                 interval_zero,
   input  logic [afs_pkg::SKIP_BITS-1:0]        skip_eff,
   input  logic [afs_pkg::FRAME_BITS-1:0]       frame,
   input  logic [afs_pkg::FRAME_BITS-1:0]       lo,
   input  logic [afs_pkg::FRAME_BITS-1:0]       hi,
   input  logic                                 backward,
   input  logic                                 both_way,
   input  logic                                 play_once,
   output logic [afs_pkg::FRAME_BITS-1:0]       frame_out,
   output logic                                 backward_out
);

   localparam int FB = afs_pkg::FRAME_BITS;
   localparam int TB = afs_pkg::TIME_BITS;
   localparam int SB = afs_pkg::SKIP_BITS;
   localparam int PB = FB + 1 + SB;

   logic [FB:0]   count_ff, count_in;
   logic [FB:0]   step_ff, step_in;
   logic [FB-1:0] stepped_ff, stepped_in;
   logic [FB-1:0] final_ff, final_in;
   logic          bw_ff, bw_in;

   logic          q_sat;
   logic [PB-1:0] prod;
   logic [FB:0]   back_diff;
   logic [FB:0]   fwd_sum;
   logic [SB:0]   back_turn;
   logic [FB:0]   turn_diff;
   logic          wrap_cond;
   logic          bw_mid;

   // Missed intervals plus one, saturated at the frame range.
   always_comb begin
      q_sat = (|quotient[TB-1:FB]) || (&quotient[FB-1:0]);
      if (interval_zero) begin
         count_in = (FB+1)'(1);
      end else if (q_sat) begin
         count_in = {1'b1, {FB{1'b0}}};
      end else begin
         count_in = {1'b0, quotient[FB-1:0]} + (FB+1)'(1);
      end
   end

   always_comb begin
      prod = PB'(count_ff) * PB'(skip_eff);
      if ((|prod[PB-1:FB+1]) || (prod[FB] && (|prod[FB-1:0]))) begin
         step_in = {1'b1, {FB{1'b0}}};
      end else begin
         step_in = prod[FB:0];
      end
   end

   always_comb begin
      back_diff = {1'b0, frame} - step_ff;
      fwd_sum   = {1'b0, frame} + step_ff;
      if (backward) begin
         if ((frame >= FB'(skip_eff)) && ({1'b0, frame} >= step_ff)
             && (back_diff[FB-1:0] >= lo)) begin
            stepped_in = back_diff[FB-1:0];
         end else begin
            stepped_in = lo;
         end
      end else begin
         if (fwd_sum < {1'b0, hi}) begin
            stepped_in = fwd_sum[FB-1:0];
         end else begin
            stepped_in = hi;
         end
      end
   end

   always_comb begin
      back_turn = {skip_eff, 1'b0};
      turn_diff = {1'b0, stepped_ff} - (FB+1)'(back_turn);
      wrap_cond = !backward && !play_once && (hi <= stepped_ff);
      final_in  = stepped_ff;
      bw_mid    = backward;
      if (wrap_cond) begin
         if (both_way) begin
            if (({1'b0, stepped_ff} >= (FB+1)'(back_turn)) && (turn_diff[FB-1:0] >= lo)) begin
               final_in = turn_diff[FB-1:0];
            end else begin
               final_in = lo;
            end
            bw_mid = 1'b1;
         end else begin
            final_in = lo;
         end
      end
      bw_in = bw_mid && (final_in != lo);
   end

   always_ff @(posedge clock) begin
      if (ctl.count_en) begin
         count_ff <= count_in;
      end
      if (ctl.mul_en) begin
         step_ff <= step_in;
      end
      if (ctl.step_en) begin
         stepped_ff <= stepped_in;
      end
      if (ctl.wrap_en) begin
         final_ff <= final_in;
         bw_ff    <= bw_in;
      end
   end

   assign frame_out    = final_ff;
   assign backward_out = bw_ff;

endmodule

### rtl/core/animation_frame_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_frame_sequencer
// One animation channel: timestamped tick, restart, pause and resume commands
// drive a frame counter with loop, once and ping-pong modes.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction. Restart,
// pause, resume and ticks that are paused or not yet due go straight to the
// emit state, which registers the response once the output slot is free. A due
// tick with a nonzero frame interval first runs the bit-serial divider that
// counts missed intervals one quotient bit per cycle over the 32-bit elapsed
// time, followed by the count, multiply, step and wrap stages; with a zero
// interval the divider is skipped. One request is processed at a time, but a new
// request is accepted while the previous response is still waiting.
// Configuration writes must happen only while the block is idle.
// ----------------------------------------------------------------------------
module animation_frame_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // now_time [31:0], start_offset [47:32]
   input  logic [47:0]                           req_tdata,
   // command [1:0]
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // frame_number [15:0], playing_backward [16], frame_changed [17],
   // is_paused [18], zero [23:19]
   output logic [23:0]                           rsp_tdata,
   input  logic                                  csr_we,
   input  logic [afs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [afs_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int FB = afs_pkg::FRAME_BITS;
   localparam int TB = afs_pkg::TIME_BITS;
   localparam int IB = afs_pkg::INTERVAL_BITS;
   localparam int SB = afs_pkg::SKIP_BITS;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DIVIDE = 8'b0000_0010,
      ST_COUNT  = 8'b0000_0100,
      ST_MUL    = 8'b0000_1000,
      ST_STEP   = 8'b0001_0000,
      ST_WRAP   = 8'b0010_0000,
      ST_COMMIT = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [FB-1:0] first_ff, first_in;
   logic [FB-1:0] last_ff, last_in;
   logic [IB-1:0] interval_ff, interval_in;
   logic [SB-1:0] skip_ff, skip_in;
   logic          both_way_ff, both_way_in;
   logic          once_ff, once_in;

   logic [FB-1:0] frame_ff, frame_in;
   logic [TB-1:0] due_ff, due_in;
   logic          bw_ff, bw_in;
   logic          paused_ff, paused_in;
   logic          changed_ff, changed_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [FB-1:0] rsp_frame_ff, rsp_frame_in;
   logic          rsp_bw_ff, rsp_bw_in;
   logic          rsp_changed_ff, rsp_changed_in;
   logic          rsp_paused_ff, rsp_paused_in;

   afs_pkg::command_type   cmd;
   afs_pkg::stage_ctl_type ctl;
   logic [TB-1:0]          now_time;
   logic [FB-1:0]          start_offset;
   logic [FB:0]            restart_sum;
   logic                   req_fire;
   logic                   tick_due;
   logic                   div_start;
   logic                   div_done;
   logic [TB-1:0]          quotient;
   logic [TB-1:0]          elapsed;
   logic                   interval_zero;
   logic [SB-1:0]          skip_eff;
   logic [FB-1:0]          unit_frame;
   logic                   unit_bw;
   logic                   emit_ok;

   assign now_time      = req_tdata[TB-1:0];
   assign start_offset  = req_tdata[TB+FB-1:TB];
   assign cmd           = afs_pkg::command_type'(req_tuser);
   assign req_tready    = (state_ff == ST_IDLE);
   assign req_fire      = req_tvalid && req_tready;
   assign interval_zero = (interval_ff == '0);
   assign skip_eff      = (skip_ff == '0) ? SB'(1) : skip_ff;
   assign tick_due      = !paused_ff && (due_ff <= now_time);
   assign elapsed       = now_time - due_ff;
   assign restart_sum   = {1'b0, first_ff} + {1'b0, start_offset};
   assign emit_ok       = !rsp_valid_ff || rsp_tready;

   always_comb begin
      first_in    = first_ff;
      last_in     = last_ff;
      interval_in = interval_ff;
      skip_in     = skip_ff;
      both_way_in = both_way_ff;
      once_in     = once_ff;
      if (csr_we) begin
         unique case (csr_index)
            afs_pkg::CSR_FIRST_FRAME:    first_in    = csr_wdata[FB-1:0];
            afs_pkg::CSR_LAST_FRAME:     last_in     = csr_wdata[FB-1:0];
            afs_pkg::CSR_FRAME_INTERVAL: interval_in = csr_wdata[IB-1:0];
            afs_pkg::CSR_SKIP_STEP:      skip_in     = csr_wdata[SB-1:0];
            afs_pkg::CSR_BOTH_WAY:       both_way_in = csr_wdata[0];
            afs_pkg::CSR_PLAY_ONCE:      once_in     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      frame_in       = frame_ff;
      due_in         = due_ff;
      bw_in          = bw_ff;
      paused_in      = paused_ff;
      changed_in     = changed_ff;
      div_start      = 1'b0;
      ctl            = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_frame_in   = rsp_frame_ff;
      rsp_bw_in      = rsp_bw_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_paused_in  = rsp_paused_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               changed_in = 1'b0;
               state_in   = ST_EMIT;
               unique case (cmd)
                  afs_pkg::CMD_TICK: begin
                     if (tick_due) begin
                        due_in = now_time + TB'(interval_ff);
                        if (interval_zero) begin
                           state_in = ST_COUNT;
                        end else begin
                           div_start = 1'b1;
                           state_in  = ST_DIVIDE;
                        end
                     end
                  end
                  afs_pkg::CMD_RESTART: begin
                     frame_in = restart_sum[FB] ? {FB{1'b1}} : restart_sum[FB-1:0];
                     due_in   = now_time;
                  end
                  afs_pkg::CMD_PAUSE:  paused_in = 1'b1;
                  afs_pkg::CMD_RESUME: paused_in = 1'b0;
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            ctl.count_en = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            ctl.mul_en = 1'b1;
            state_in   = ST_STEP;
         end
         ST_STEP: begin
            ctl.step_en = 1'b1;
            state_in    = ST_WRAP;
         end
         ST_WRAP: begin
            ctl.wrap_en = 1'b1;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            frame_in   = unit_frame;
            bw_in      = unit_bw;
            changed_in = (unit_frame != frame_ff);
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in   = 1'b1;
               rsp_frame_in   = frame_ff;
               rsp_bw_in      = bw_ff;
               rsp_changed_in = changed_ff;
               rsp_paused_in  = paused_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   afs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (elapsed),
      .divisor  (interval_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   afs_frame_unit u_frame_unit (
      .clock         (clock),
      .ctl           (ctl),
      .quotient      (quotient),
      .interval_zero (interval_zero),
      .skip_eff      (skip_eff),
      .frame         (frame_ff),
      .lo            (first_ff),
      .hi            (last_ff),
      .backward      (bw_ff),
      .both_way      (both_way_ff),
      .play_once     (once_ff),
      .frame_out     (unit_frame),
      .backward_out  (unit_bw)
   );

   always_ff @(posedge clock) begin
      rsp_frame_ff   <= rsp_frame_in;
      rsp_bw_ff      <= rsp_bw_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_paused_ff  <= rsp_paused_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= FB'(0);
         last_ff      <= FB'(1);
         interval_ff  <= IB'(1);
         skip_ff      <= SB'(1);
         both_way_ff  <= 1'b0;
         once_ff      <= 1'b0;
         frame_ff     <= '0;
         due_ff       <= '0;
         bw_ff        <= 1'b0;
         paused_ff    <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         interval_ff  <= interval_in;
         skip_ff      <= skip_in;
         both_way_ff  <= both_way_in;
         once_ff      <= once_in;
         frame_ff     <= frame_in;
         due_ff       <= due_in;
         bw_ff        <= bw_in;
         paused_ff    <= paused_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_paused_ff, rsp_changed_ff, rsp_bw_ff, rsp_frame_ff};

endmodule

### dv/animation_frame_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_frame_sequencer_tb
// Self-checking testbench of the animation frame sequencer. A built-in frame
// predictor computes the status of every accepted command, and each response
// transaction is compared field by field with the oldest expected status.
// Directed commands and settings come first, then randomized command streams
// under many register settings, with random idling on both stream sides and
// one long response stall that backs up the request side.
// ----------------------------------------------------------------------------
module animation_frame_sequencer_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int MAX_REPORTS    = 10;
   localparam int FBITS          = afs_pkg::FRAME_BITS;
   localparam int TBITS          = afs_pkg::TIME_BITS;
   localparam longint unsigned FRAME_MAX = (64'd1 << FBITS) - 1;

   typedef struct {
      logic [FBITS-1:0] frame;
      logic             backward;
      logic             changed;
      logic             paused;
   } frame_status_type;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [47:0]                        req_tdata;
   logic [1:0]                         req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [23:0]                        rsp_tdata;
   logic                               csr_we;
   logic [afs_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [afs_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   // Predicted channel state and register copy.
   logic [FBITS-1:0]                  cur_frame;
   logic [TBITS-1:0]                  due_time;
   logic                              backward_now;
   logic                              paused_now;
   logic [FBITS-1:0]                  cfg_first;
   logic [FBITS-1:0]                  cfg_last;
   logic [afs_pkg::INTERVAL_BITS-1:0] cfg_interval;
   logic [afs_pkg::SKIP_BITS-1:0]     cfg_skip;
   logic                              cfg_both_way;
   logic                              cfg_play_once;

   frame_status_type     expected_status[$];
   logic [TBITS-1:0]     stream_now;
   int                   errors;
   bit                   idle_en;
   int                   hold_request;
   int                   stall_left;
   int                   quiet_cycles;

   animation_frame_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Frame predictor.
   function automatic void advance_frame(input logic [TBITS-1:0] stamp);
      logic [TBITS-1:0] elapsed;
      longint unsigned count, step, f, lo, hi, s, back;
      if (cfg_interval != 0) begin
         elapsed = stamp - due_time;
         count = elapsed / cfg_interval;
         count = (count >= FRAME_MAX) ? FRAME_MAX + 1 : count + 1;
      end else begin
         count = 1;
      end
      due_time = stamp + cfg_interval;
      s = (cfg_skip == 0) ? 1 : cfg_skip;
      step = count * s;
      if (step > FRAME_MAX + 1) step = FRAME_MAX + 1;
      f = cur_frame;
      lo = cfg_first;
      hi = cfg_last;
      if (backward_now) begin
         if (f >= s && f >= step && f - step >= lo) f = f - step;
         else f = lo;
      end else begin
         if (f + step < hi) f = f + step;
         else f = hi;
      end
      if (!backward_now && !cfg_play_once && hi <= f) begin
         if (cfg_both_way) begin
            back = 2 * s;
            if (f >= back && f - back >= lo) f = f - back;
            else f = lo;
            backward_now = 1'b1;
         end else begin
            f = lo;
         end
      end
      if (backward_now && f == lo) backward_now = 1'b0;
      cur_frame = f[FBITS-1:0];
   endfunction

   function automatic void predict_status(input afs_pkg::command_type cmd,
                                          input logic [TBITS-1:0] stamp,
                                          input logic [FBITS-1:0] offset);
      frame_status_type st;
      logic [FBITS-1:0] prior;
      longint unsigned sum;
      prior = cur_frame;
      st.changed = 1'b0;
      case (cmd)
         afs_pkg::CMD_TICK: begin
            if (!paused_now && due_time <= stamp) begin
               advance_frame(stamp);
               st.changed = (cur_frame != prior);
            end
         end
         afs_pkg::CMD_RESTART: begin
            sum = longint'(cfg_first) + longint'(offset);
            if (sum > FRAME_MAX) sum = FRAME_MAX;
            cur_frame = sum[FBITS-1:0];
            due_time = stamp;
         end
         afs_pkg::CMD_PAUSE: paused_now = 1'b1;
         default: paused_now = 1'b0;
      endcase
      st.frame = cur_frame;
      st.backward = backward_now;
      st.paused = paused_now;
      expected_status.push_back(st);
   endfunction

   // Response side: random stalls plus an occasional long hold-off.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_en && $urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      frame_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_status.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected response transaction, data %h",
                        $realtime, rsp_tdata);
         end else begin
            want = expected_status.pop_front();
            if (rsp_tdata[15:0] !== want.frame || rsp_tdata[16] !== want.backward ||
                rsp_tdata[17] !== want.changed || rsp_tdata[18] !== want.paused ||
                rsp_tdata[23:19] !== 5'd0) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("%0t: mismatch: expected frame %0d bwd %b chg %b pause %b",
                           $realtime, want.frame, want.backward, want.changed,
                           want.paused);
                  $display("%0t:           got frame %0d bwd %b chg %b pause %b pad %b",
                           $realtime, rsp_tdata[15:0], rsp_tdata[16], rsp_tdata[17],
                           rsp_tdata[18], rsp_tdata[23:19]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_command(input afs_pkg::command_type cmd,
                               input logic [TBITS-1:0] stamp,
                               input logic [FBITS-1:0] offset);
      int gap;
      gap = (idle_en && $urandom_range(99) < 10) ? $urandom_range(1, 40) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {offset, stamp};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_status(cmd, stamp, offset);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drain(input int settle);
      while (expected_status.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input afs_pkg::csr_index_type idx,
                            input logic [afs_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         afs_pkg::CSR_FIRST_FRAME:    cfg_first = value;
         afs_pkg::CSR_LAST_FRAME:     cfg_last = value;
         afs_pkg::CSR_FRAME_INTERVAL: cfg_interval = value;
         afs_pkg::CSR_SKIP_STEP:      cfg_skip = value[afs_pkg::SKIP_BITS-1:0];
         afs_pkg::CSR_BOTH_WAY:       cfg_both_way = value[0];
         afs_pkg::CSR_PLAY_ONCE:      cfg_play_once = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Unused upper data bits carry random junk to show they are ignored.
   task automatic apply_setting(input logic [15:0] first, input logic [15:0] last,
                                input logic [15:0] interval, input logic [7:0] skip,
                                input logic both_way, input logic play_once);
      logic [15:0] junk;
      stop_sending();
      wait_drain(4);
      junk = 16'($urandom);
      write_csr(afs_pkg::CSR_FIRST_FRAME, first);
      write_csr(afs_pkg::CSR_LAST_FRAME, last);
      write_csr(afs_pkg::CSR_FRAME_INTERVAL, interval);
      write_csr(afs_pkg::CSR_SKIP_STEP, {junk[15:8], skip});
      write_csr(afs_pkg::CSR_BOTH_WAY, {junk[14:0], both_way});
      write_csr(afs_pkg::CSR_PLAY_ONCE, {junk[15:1], play_once});
   endtask

   task automatic apply_random_setting();
      logic [15:0] first, last, interval;
      logic [7:0] skip;
      int r;
      r = $urandom_range(9);
      first = (r == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
      if (r == 1) last = 16'($urandom);
      else if (r == 2) last = 16'($urandom_range(0, first));
      else if (first > 16'd65495) last = 16'hFFFF;
      else last = first + 16'($urandom_range(0, 40));
      r = $urandom_range(9);
      interval = (r < 2) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, 10)) : 16'($urandom);
      r = $urandom_range(9);
      skip = (r == 0) ? 8'd0 : (r == 1) ? 8'($urandom) : 8'($urandom_range(1, 5));
      apply_setting(first, last, interval, skip, 1'($urandom_range(1)),
                    1'($urandom_range(1)));
   endtask

   // Mostly ordered timestamps and ticks, with some jumps and stray values.
   task automatic send_random_command();
      afs_pkg::command_type cmd;
      logic [15:0] offset;
      int r;
      int span;
      r = $urandom_range(99);
      cmd = (r < 75) ? afs_pkg::CMD_TICK : (r < 87) ? afs_pkg::CMD_RESTART :
            (r < 91) ? afs_pkg::CMD_PAUSE : afs_pkg::CMD_RESUME;
      r = $urandom_range(99);
      if (r < 2) stream_now = $urandom;
      else if (r < 4) stream_now = stream_now - $urandom_range(0, 50);
      else stream_now = stream_now + $urandom_range(0, 2 * cfg_interval + 2);
      span = (cfg_last > cfg_first) ? cfg_last - cfg_first + 4 : 8;
      offset = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
      send_command(cmd, stream_now, offset);
   endtask

   task automatic test_basic_commands();
      apply_setting(16'd10, 16'd20, 16'd5, 8'd1, 1'b0, 1'b0);
      send_command(afs_pkg::CMD_RESTART, 32'd100, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd100, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd102, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd116, 16'd0);
      send_command(afs_pkg::CMD_PAUSE, 32'd120, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd200, 16'd0);
      send_command(afs_pkg::CMD_RESUME, 32'd200, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd200, 16'd0);
      send_command(afs_pkg::CMD_RESTART, 32'd300, 16'hFFFF);
      send_command(afs_pkg::CMD_TICK, 32'd300, 16'd0);
      send_command(afs_pkg::CMD_RESTART, 32'd0, 16'd3);
      send_command(afs_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd3, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd4, 16'd0);
   endtask

   task automatic test_play_modes();
      // Ping-pong turn that clamps at the first frame, zero interval.
      apply_setting(16'd2, 16'd6, 16'd0, 8'd3, 1'b1, 1'b0);
      send_command(afs_pkg::CMD_RESTART, 32'd10, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd10, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd10, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd11, 16'd0);
      // Once mode at the widest range and largest step.
      apply_setting(16'd0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b1);
      send_command(afs_pkg::CMD_RESTART, 32'd0, 16'd65000);
      send_command(afs_pkg::CMD_TICK, 32'd0, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'd0);
      // Zero skip step and a first frame above the last frame.
      apply_setting(16'd9, 16'd4, 16'd1, 8'd0, 1'b1, 1'b0);
      send_command(afs_pkg::CMD_RESTART, 32'd0, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd1, 16'd0);
      send_command(afs_pkg::CMD_TICK, 32'd2, 16'd0);
   endtask

   task automatic test_random_settings(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         apply_random_setting();
         stream_now = $urandom;
         repeat (per_phase) send_random_command();
      end
   endtask

   task automatic test_no_idle();
      idle_en = 1'b0;
      test_random_settings(2, 75);
      idle_en = 1'b1;
   endtask

   task automatic test_backpressure();
      apply_random_setting();
      @(posedge clock);
      hold_request = 300;
      repeat (40) send_random_command();
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = afs_pkg::CMD_TICK;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_index    = afs_pkg::CSR_FIRST_FRAME;
      csr_wdata    = '0;
      errors       = 0;
      idle_en      = 1'b1;
      hold_request = 0;
      stall_left   = 0;
      quiet_cycles = 0;
      stream_now   = '0;
      cur_frame     = '0;
      due_time      = '0;
      backward_now  = 1'b0;
      paused_now    = 1'b0;
      cfg_first     = 16'd0;
      cfg_last      = 16'd1;
      cfg_interval  = 16'd1;
      cfg_skip      = 8'd1;
      cfg_both_way  = 1'b0;
      cfg_play_once = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_commands();
      test_play_modes();
      test_random_settings(10, 110);
      test_no_idle();
      test_backpressure();

      stop_sending();
      wait_drain(DRAIN_CYCLES);
      errors += expected_status.size();
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
